>>> rtl/core/pip_pkg.sv
// Shared types and constants for the point-in-polygon test unit.
`default_nettype none

package pip_pkg;

    localparam int DEF_MAX_VERTICES = 64;
    localparam int DEF_COORD_BITS   = 16;

    localparam int REQ_W      = 2;
    localparam int OUT_CNT_W  = 7;
    localparam int M_TDATA_W  = 16;

    localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd0;
    localparam logic [REQ_W-1:0] REQ_ADD   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_TEST  = 2'd2;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic clear_en;
        logic add_en;
        logic query_ld;
        logic rd_en;
        logic close;
        logic out_ld;
    } pip_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic empty;
        logic res_ready;
    } pip_sts_t;

endpackage

`default_nettype wire

>>> rtl/core/pip_ctrl.sv
// Controller state machine: request decode, vertex walk sequencing and output handshake.
`default_nettype none

module pip_ctrl #(
    parameter int MAX_VERTICES = pip_pkg::DEF_MAX_VERTICES
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [pip_pkg::REQ_W-1:0]        req_type,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    input  wire logic [$clog2(MAX_VERTICES+1)-1:0] vcount,
    input  wire pip_pkg::pip_sts_t                sts,
    output pip_pkg::pip_cmd_t                     cmd,
    output logic [$clog2(MAX_VERTICES)-1:0]       rd_addr
);

    localparam int ADDR_W = $clog2(MAX_VERTICES);
    localparam int CNT_W  = $clog2(MAX_VERTICES + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_CLOSE,
        ST_DRAIN
    } state_t;

    state_t             state_reg;
    logic [ADDR_W-1:0]  addr_reg;
    logic               m_tvalid_reg;
    logic               s_fire;
    logic               walk_last;

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_fire    = s_tvalid && s_tready;
    assign m_tvalid  = m_tvalid_reg;
    assign rd_addr   = addr_reg;
    assign walk_last = ((CNT_W'(addr_reg) + CNT_W'(1)) == vcount);

    always_comb begin
        cmd = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    unique case (req_type)
                        pip_pkg::REQ_CLEAR: cmd.clear_en = 1'b1;
                        pip_pkg::REQ_ADD:   cmd.add_en   = 1'b1;
                        pip_pkg::REQ_TEST:  cmd.query_ld = 1'b1;
                        default:            cmd          = '0;
                    endcase
                end
            end
            ST_WALK:  cmd.rd_en  = 1'b1;
            ST_CLOSE: cmd.close  = 1'b1;
            ST_DRAIN: cmd.out_ld = sts.res_ready && (!m_tvalid_reg || m_tready);
            default:  cmd        = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            addr_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cmd.out_ld) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (cmd.query_ld) begin
                        addr_reg  <= '0;
                        // empty polygon: only the closing token runs through
                        state_reg <= sts.empty ? ST_CLOSE : ST_WALK;
                    end
                end
                ST_WALK: begin
                    addr_reg <= addr_reg + ADDR_W'(1);
                    if (walk_last) begin
                        state_reg <= ST_CLOSE;
                    end
                end
                ST_CLOSE: state_reg <= ST_DRAIN;
                ST_DRAIN: begin
                    if (cmd.out_ld) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    a_out_ld_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_ld |-> sts.res_ready)
        else $error("result loaded before the count finished");

    a_out_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_ld |-> (!m_tvalid_reg || m_tready))
        else $error("result register overwritten while waiting");

    a_walk_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WALK) |-> !sts.empty)
        else $error("vertex walk on an empty polygon");

endmodule

`default_nettype wire

>>> rtl/core/pip_dp.sv
// Datapath: vertex store, edge pipeline with cross-multiplied crossing test, result register.
`default_nettype none

module pip_dp #(
    parameter int MAX_VERTICES = pip_pkg::DEF_MAX_VERTICES,
    parameter int COORD_BITS   = pip_pkg::DEF_COORD_BITS
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire pip_pkg::pip_cmd_t                 cmd,
    input  wire logic [$clog2(MAX_VERTICES)-1:0]   rd_addr,
    input  wire logic signed [COORD_BITS-1:0]      coord_x,
    input  wire logic signed [COORD_BITS-1:0]      coord_y,
    output logic [$clog2(MAX_VERTICES+1)-1:0]      vcount,
    output pip_pkg::pip_sts_t                      sts,
    output logic                                   inside_res,
    output logic [pip_pkg::OUT_CNT_W-1:0]          crossing_count,
    output logic [pip_pkg::OUT_CNT_W-1:0]          vertices_held
);

    localparam int ADDR_W = $clog2(MAX_VERTICES);
    localparam int CNT_W  = $clog2(MAX_VERTICES + 1);
    localparam int D_W    = COORD_BITS + 1;
    localparam int P_W    = 2 * D_W;

    logic signed [COORD_BITS-1:0] vx_mem [MAX_VERTICES];
    logic signed [COORD_BITS-1:0] vy_mem [MAX_VERTICES];

    logic [CNT_W-1:0]             vcount_reg;
    logic                         full;

    logic signed [COORD_BITS-1:0] qx_reg, qy_reg;
    logic signed [COORD_BITS-1:0] rd_x_reg, rd_y_reg;
    logic                         rd_vld_reg, rd_first_reg, rd_close_reg;
    logic signed [COORD_BITS-1:0] first_x_reg, first_y_reg;
    logic signed [COORD_BITS-1:0] prev_x_reg, prev_y_reg;

    logic signed [COORD_BITS-1:0] bx, by;
    logic                         straddle, edge_go;
    logic signed [D_W-1:0]        dbx, dpy, dpx, dy;

    logic signed [D_W-1:0]        e_dbx_reg, e_dpy_reg, e_dpx_reg, e_dy_reg;
    logic                         e_hit_reg, e_last_reg;

    logic signed [P_W-1:0]        m1_reg, m2_reg;
    logic                         m_dyneg_reg, m_hit_reg, m_last_reg;
    logic                         right;

    logic [CNT_W-1:0]             cnt_reg;
    logic                         res_ready_reg;

    logic                         out_inside_reg;
    logic [pip_pkg::OUT_CNT_W-1:0] out_cnt_reg, out_held_reg;

    assign full          = (vcount_reg == CNT_W'(MAX_VERTICES));
    assign vcount        = vcount_reg;
    assign sts.empty     = (vcount_reg == '0);
    assign sts.res_ready = res_ready_reg;

    // Vertex store: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (cmd.add_en && !full) begin
            vx_mem[vcount_reg[ADDR_W-1:0]] <= coord_x;
            vy_mem[vcount_reg[ADDR_W-1:0]] <= coord_y;
        end
        if (cmd.rd_en) begin
            rd_x_reg <= vx_mem[rd_addr];
            rd_y_reg <= vy_mem[rd_addr];
        end
    end

    // Edge former: previous vertex to the one just read, or last back to first
    always_comb begin
        bx       = rd_close_reg ? first_x_reg : rd_x_reg;
        by       = rd_close_reg ? first_y_reg : rd_y_reg;
        straddle = (prev_y_reg > qy_reg) != (by > qy_reg);
        edge_go  = rd_close_reg ? (vcount_reg != '0) : (rd_vld_reg && !rd_first_reg);
        dbx      = {bx[COORD_BITS-1], bx} - {prev_x_reg[COORD_BITS-1], prev_x_reg};
        dpy      = {qy_reg[COORD_BITS-1], qy_reg} - {prev_y_reg[COORD_BITS-1], prev_y_reg};
        dpx      = {qx_reg[COORD_BITS-1], qx_reg} - {prev_x_reg[COORD_BITS-1], prev_x_reg};
        dy       = {by[COORD_BITS-1], by} - {prev_y_reg[COORD_BITS-1], prev_y_reg};
    end

    // dy > 0: crossing right when dbx*dpy > dpx*dy; dy < 0 flips the compare
    assign right = m_dyneg_reg ? (m2_reg > m1_reg) : (m1_reg > m2_reg);

    always_ff @(posedge aclk) begin
        if (cmd.query_ld) begin
            qx_reg <= coord_x;
            qy_reg <= coord_y;
        end
        if (rd_vld_reg) begin
            prev_x_reg <= rd_x_reg;
            prev_y_reg <= rd_y_reg;
            if (rd_first_reg) begin
                first_x_reg <= rd_x_reg;
                first_y_reg <= rd_y_reg;
            end
        end
        e_dbx_reg   <= dbx;
        e_dpy_reg   <= dpy;
        e_dpx_reg   <= dpx;
        e_dy_reg    <= dy;
        m1_reg      <= P_W'(e_dbx_reg) * P_W'(e_dpy_reg);
        m2_reg      <= P_W'(e_dpx_reg) * P_W'(e_dy_reg);
        m_dyneg_reg <= e_dy_reg[D_W-1];
        if (cmd.out_ld) begin
            out_inside_reg <= cnt_reg[0];
            out_cnt_reg    <= pip_pkg::OUT_CNT_W'(cnt_reg);
            out_held_reg   <= pip_pkg::OUT_CNT_W'(vcount_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vcount_reg    <= '0;
            rd_vld_reg    <= 1'b0;
            rd_first_reg  <= 1'b0;
            rd_close_reg  <= 1'b0;
            e_hit_reg     <= 1'b0;
            e_last_reg    <= 1'b0;
            m_hit_reg     <= 1'b0;
            m_last_reg    <= 1'b0;
            cnt_reg       <= '0;
            res_ready_reg <= 1'b0;
        end else begin
            if (cmd.clear_en) begin
                vcount_reg <= '0;
            end else if (cmd.add_en && !full) begin
                vcount_reg <= vcount_reg + CNT_W'(1);
            end
            rd_vld_reg   <= cmd.rd_en;
            rd_first_reg <= cmd.rd_en && (rd_addr == '0);
            rd_close_reg <= cmd.close;
            e_hit_reg    <= edge_go && straddle;
            e_last_reg   <= rd_close_reg;
            m_hit_reg    <= e_hit_reg;
            m_last_reg   <= e_last_reg;
            if (cmd.query_ld) begin
                cnt_reg       <= '0;
                res_ready_reg <= 1'b0;
            end else begin
                if (m_hit_reg && right) begin
                    cnt_reg <= cnt_reg + CNT_W'(1);
                end
                if (m_last_reg) begin
                    res_ready_reg <= 1'b1;
                end else if (cmd.out_ld) begin
                    res_ready_reg <= 1'b0;
                end
            end
        end
    end

    assign inside_res     = out_inside_reg;
    assign crossing_count = out_cnt_reg;
    assign vertices_held  = out_held_reg;

    a_rd_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.rd_en |-> (CNT_W'(rd_addr) < vcount_reg))
        else $error("vertex read beyond the held count");

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        res_ready_reg |-> (cnt_reg <= vcount_reg))
        else $error("more crossings than edges");

    a_held_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        vcount_reg <= CNT_W'(MAX_VERTICES))
        else $error("vertex count past the store depth");

endmodule

`default_nettype wire

>>> rtl/core/point_in_polygon_test_unit.sv
// Top level of the point-in-polygon test unit: stream ports, controller and datapath.
`default_nettype none

// Holds up to MAX_VERTICES polygon vertices and answers even-odd point-in-polygon
// queries. s_tuser selects the request: clear, add vertex (dropped when the store is
// full) or test point; only a test returns an item on the m_ side. In a test the single
// read port of the vertex store delivers one vertex per cycle, each edge then passes a
// difference, a multiply and a compare stage, and the closing edge follows the last
// vertex. A new request is taken while the previous result still waits in the output
// register.
module point_in_polygon_test_unit #(
    parameter int MAX_VERTICES = pip_pkg::DEF_MAX_VERTICES,
    parameter int COORD_BITS   = pip_pkg::DEF_COORD_BITS
) (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire logic                                   s_tvalid,
    output logic                                        s_tready,
    // coord_x, coord_y, zero fill
    input  wire logic [((2*COORD_BITS+7)/8)*8-1:0]      s_tdata,
    // req_type
    input  wire logic [pip_pkg::REQ_W-1:0]              s_tuser,
    output logic                                        m_tvalid,
    input  wire logic                                   m_tready,
    // inside_res, crossing_count, vertices_held, zero fill
    output logic [pip_pkg::M_TDATA_W-1:0]               m_tdata
);

    localparam int ADDR_W = $clog2(MAX_VERTICES);
    localparam int CNT_W  = $clog2(MAX_VERTICES + 1);

    pip_pkg::pip_cmd_t             cmd;
    pip_pkg::pip_sts_t             sts;
    logic [ADDR_W-1:0]             rd_addr;
    logic [CNT_W-1:0]              vcount;
    logic signed [COORD_BITS-1:0]  coord_x, coord_y;
    logic                          inside_res;
    logic [pip_pkg::OUT_CNT_W-1:0] crossing_count, vertices_held;

    assign coord_x = s_tdata[COORD_BITS-1:0];
    assign coord_y = s_tdata[2*COORD_BITS-1:COORD_BITS];

    pip_ctrl #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .req_type (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .vcount   (vcount),
        .sts      (sts),
        .cmd      (cmd),
        .rd_addr  (rd_addr)
    );

    pip_dp #(
        .MAX_VERTICES (MAX_VERTICES),
        .COORD_BITS   (COORD_BITS)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .rd_addr        (rd_addr),
        .coord_x        (coord_x),
        .coord_y        (coord_y),
        .vcount         (vcount),
        .sts            (sts),
        .inside_res     (inside_res),
        .crossing_count (crossing_count),
        .vertices_held  (vertices_held)
    );

    assign m_tdata = {1'b0, vertices_held, crossing_count, inside_res};

endmodule

`default_nettype wire

>>> test/tb.sv
// Testbench for the point-in-polygon test unit: directed and random requests, checked by a predictor.
`timescale 1ns / 100ps

module tb;

    localparam int CW         = pip_pkg::DEF_COORD_BITS;
    localparam int MAXV       = pip_pkg::DEF_MAX_VERTICES;
    localparam int S_DATA_W   = ((2*CW+7)/8)*8;
    localparam int CYCLE_CAP  = 1000000;
    localparam int RAND_ITEMS = 400;

    // request code the block leaves unused
    localparam logic [pip_pkg::REQ_W-1:0] REQ_UNUSED = 2'd3;

    typedef logic signed [CW-1:0] coord_t;

    typedef struct packed {
        logic                          in_poly;
        logic [pip_pkg::OUT_CNT_W-1:0] crossings;
        logic [pip_pkg::OUT_CNT_W-1:0] held;
    } answer_t;

    logic                           aclk     = 1'b0;
    logic                           aresetn  = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [S_DATA_W-1:0]            s_tdata  = '0;
    logic [pip_pkg::REQ_W-1:0]      s_tuser  = '0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [pip_pkg::M_TDATA_W-1:0]  m_tdata;

    // predictor state: polygon vertices as the block should hold them
    coord_t  poly_x [MAXV];
    coord_t  poly_y [MAXV];
    int      poly_count = 0;
    answer_t expected_answers [$];

    bit idle_on         = 1'b0;
    int stall_left      = 0;
    int errors          = 0;
    int items_sent      = 0;
    int answers_checked = 0;
    int largest_poly    = 0;
    int cycles          = 0;

    point_in_polygon_test_unit u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_CAP) begin
            $display("%0t: timeout after %0d cycles", $time, cycles);
            $display("TEST FAILED");
            $finish;
        end
    end

    // mostly short gaps, now and then a long one
    function automatic int idle_len();
        if ($urandom_range(0, 9) != 0)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    always @(posedge aclk) begin
        if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left = stall_left - 1;
        end else if (idle_on && $urandom_range(0, 3) == 0) begin
            m_tready <= 1'b0;
            stall_left = idle_len() - 1;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // even-odd rule with exact cross-multiplied compare, no division
    function automatic answer_t evaluate_query(coord_t qx, coord_t qy);
        answer_t ans;
        int      hits;
        int      j;
        longint  ax, ay, bx, by, px, py, dy;
        bit      right;
        hits = 0;
        px = qx;
        py = qy;
        for (int i = 0; i < poly_count; i++) begin
            j  = (i + 1 < poly_count) ? i + 1 : 0;
            ax = poly_x[i];
            ay = poly_y[i];
            bx = poly_x[j];
            by = poly_y[j];
            if ((ay > py) != (by > py)) begin
                dy = by - ay;
                if (dy > 0)
                    right = (bx - ax) * (py - ay) > (px - ax) * dy;
                else
                    right = (px - ax) * dy > (bx - ax) * (py - ay);
                if (right)
                    hits++;
            end
        end
        ans.in_poly   = hits[0];
        ans.crossings = hits[pip_pkg::OUT_CNT_W-1:0];
        ans.held      = poly_count[pip_pkg::OUT_CNT_W-1:0];
        return ans;
    endfunction

    function automatic void apply_request(logic [pip_pkg::REQ_W-1:0] req, coord_t x, coord_t y);
        case (req)
            pip_pkg::REQ_CLEAR: poly_count = 0;
            pip_pkg::REQ_ADD: begin
                // a full store drops the vertex
                if (poly_count < MAXV) begin
                    poly_x[poly_count] = x;
                    poly_y[poly_count] = y;
                    poly_count++;
                    if (poly_count > largest_poly)
                        largest_poly = poly_count;
                end
            end
            pip_pkg::REQ_TEST: expected_answers.push_back(evaluate_query(x, y));
            default: ;
        endcase
    endfunction

    task automatic send_item(input logic [pip_pkg::REQ_W-1:0] req, input coord_t x, input coord_t y);
        int                  gap;
        logic [S_DATA_W-1:0] word;
        gap  = 0;
        word = '0;
        word[CW-1:0]    = x;
        word[2*CW-1:CW] = y;
        if (idle_on && $urandom_range(0, 2) == 0)
            gap = idle_len();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= word;
        do @(posedge aclk); while (!s_tready);
        apply_request(req, x, y);
        if (req != REQ_UNUSED)
            items_sent++;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_answers.size() != 0)
            @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        answer_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_answers.size() == 0) begin
                errors++;
                $display("%0t: answer with none expected, actual tdata %h", $time, m_tdata);
            end else begin
                want = expected_answers.pop_front();
                answers_checked++;
                if (m_tdata[0] !== want.in_poly) begin
                    errors++;
                    $display("%0t: inside_res expected %0d actual %0d",
                             $time, want.in_poly, m_tdata[0]);
                end
                if (m_tdata[7:1] !== want.crossings) begin
                    errors++;
                    $display("%0t: crossing_count expected %0d actual %0d",
                             $time, want.crossings, m_tdata[7:1]);
                end
                if (m_tdata[14:8] !== want.held) begin
                    errors++;
                    $display("%0t: vertices_held expected %0d actual %0d",
                             $time, want.held, m_tdata[14:8]);
                end
            end
        end
    end

    function automatic coord_t pick_coord(int mode);
        int r;
        r = $urandom_range(0, 6);
        case (mode)
            0: return coord_t'($urandom());
            1: return coord_t'($urandom_range(0, 200)) - 16'sd100;
            default: begin
                case (r)
                    0: return 16'sh8000;
                    1: return 16'sh7FFF;
                    2: return 16'sh8001;
                    3: return -16'sd1;
                    4: return 16'sd0;
                    default: return coord_t'($urandom());
                endcase
            end
        endcase
    endfunction

    task automatic test_empty_and_unused();
        send_item(pip_pkg::REQ_TEST, 16'sd0, 16'sd0);
        send_item(REQ_UNUSED, 16'sd1, 16'sd1);
        send_item(pip_pkg::REQ_TEST, 16'sh7FFF, 16'sh8000);
    endtask

    task automatic test_few_vertices();
        send_item(pip_pkg::REQ_CLEAR, 16'sd0, 16'sd0);
        send_item(pip_pkg::REQ_ADD, 16'sd5, 16'sd5);
        send_item(pip_pkg::REQ_TEST, 16'sd0, 16'sd5);
        // two-point polygon: both edges cross, even count
        send_item(pip_pkg::REQ_ADD, 16'sd5, 16'sd10);
        send_item(pip_pkg::REQ_TEST, 16'sd0, 16'sd7);
    endtask

    task automatic test_sloped_triangle();
        send_item(pip_pkg::REQ_CLEAR, 16'sd0, 16'sd0);
        send_item(pip_pkg::REQ_ADD, 16'sd0, 16'sd0);
        send_item(pip_pkg::REQ_ADD, 16'sd10, 16'sd20);
        send_item(pip_pkg::REQ_ADD, 16'sd20, 16'sd0);
        send_item(pip_pkg::REQ_TEST, 16'sd10, 16'sd10);
        send_item(pip_pkg::REQ_TEST, 16'sd5, 16'sd10);   // on the left edge
        send_item(pip_pkg::REQ_TEST, 16'sd15, 16'sd10);  // on the right edge
        send_item(pip_pkg::REQ_TEST, 16'sd30, 16'sd10);
        send_item(pip_pkg::REQ_TEST, 16'sd10, 16'sd0);   // level with the flat edge
    endtask

    task automatic test_extreme_coords();
        send_item(pip_pkg::REQ_CLEAR, 16'sh7FFF, 16'sh7FFF);
        send_item(pip_pkg::REQ_ADD, 16'sh8000, 16'sh8000);
        send_item(pip_pkg::REQ_ADD, 16'sh7FFF, 16'sh8000);
        send_item(pip_pkg::REQ_ADD, 16'sh7FFF, 16'sh7FFF);
        send_item(pip_pkg::REQ_ADD, 16'sh8000, 16'sh7FFF);
        send_item(pip_pkg::REQ_TEST, 16'sh8000, 16'sd0);
        send_item(pip_pkg::REQ_TEST, 16'sh7FFF, -16'sd1);
    endtask

    task automatic test_store_full();
        int mode;
        mode = $urandom_range(0, 2);
        send_item(pip_pkg::REQ_CLEAR, 16'sd0, 16'sd0);
        for (int k = 0; k < MAXV + 4; k++)
            send_item(pip_pkg::REQ_ADD, pick_coord(mode), pick_coord(mode));
        for (int k = 0; k < 4; k++)
            send_item(pip_pkg::REQ_TEST, pick_coord(mode), pick_coord(mode));
    endtask

    task automatic test_random_polygons();
        int     r, n, mode, queries, shapes, pick;
        coord_t vx, vy, last_y;
        shapes = 0;
        last_y = '0;
        while (items_sent < RAND_ITEMS) begin
            idle_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 9) != 0)
                send_item(pip_pkg::REQ_CLEAR, coord_t'($urandom()), coord_t'($urandom()));
            r    = $urandom_range(0, 19);
            n    = (r < 2) ? $urandom_range(0, 2) :
                   (r < 19) ? $urandom_range(3, 10) : $urandom_range(11, MAXV + 3);
            mode = $urandom_range(0, 2);
            for (int k = 0; k < n; k++) begin
                vx = pick_coord(mode);
                // repeated y gives flat edges
                vy = (k > 0 && $urandom_range(0, 4) == 0) ? last_y : pick_coord(mode);
                last_y = vy;
                send_item(pip_pkg::REQ_ADD, vx, vy);
                // noise: any code, including a stray clear that breaks the shape
                if ($urandom_range(0, 29) == 0)
                    send_item(pip_pkg::REQ_W'($urandom_range(0, 3)),
                              coord_t'($urandom()), coord_t'($urandom()));
            end
            queries = $urandom_range(1, 6);
            for (int q = 0; q < queries; q++) begin
                pick = (poly_count > 0) ? $urandom_range(0, poly_count - 1) : 0;
                case ((poly_count > 0) ? $urandom_range(0, 3) : 0)
                    0, 1: send_item(pip_pkg::REQ_TEST, pick_coord(mode), pick_coord(mode));
                    2: send_item(pip_pkg::REQ_TEST, pick_coord(mode), poly_y[pick]);
                    default: send_item(pip_pkg::REQ_TEST, poly_x[pick], poly_y[pick]);
                endcase
            end
            shapes++;
            if (shapes % 7 == 3)
                wait_drained();
        end
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        idle_on = 1'b0;
        test_empty_and_unused();
        test_few_vertices();
        idle_on = 1'b1;
        test_sloped_triangle();
        test_extreme_coords();
        test_store_full();
        test_random_polygons();

        idle_on = 1'b0;
        wait_drained();
        repeat (MAXV + 16) @(posedge aclk);

        $display("Sent %0d requests, checked %0d answers, largest polygon %0d vertices.",
                 items_sent, answers_checked, largest_poly);
        $display("Covered empty and degenerate shapes, points on edges, extreme coordinates,");
        $display("store overflow, unused codes and random polygons under both-side stalls.");
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
